// ===== sv/cfb_pkg.sv =====
package cfb_pkg;

	localparam int PREAMBLE_LEN_DEF = 3;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	// input kinds carried on tuser
	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// work item handed from the front end to the serializer
	typedef struct packed {
		logic        is_hdr;
		logic        finish;   // checksum follows this item
		logic [7:0]  id;
		logic [15:0] len;
		logic [7:0]  data;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_CRC_LO,
		ST_CRC_HI
	} ser_state_t;

	// MSB-first CCITT remainder of idx << 8
	function automatic logic [15:0] crc_tab(input logic [7:0] idx);
		logic [15:0] r;
		r = {idx, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15])
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			else
				r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// byte-wise table update, low byte of the checksum indexes the table
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		return crc_tab(crc[7:0] ^ b) ^ {8'h00, crc[15:8]};
	endfunction

endpackage

// ===== sv/cfb_front.sv =====
module cfb_front
	import cfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_kind,
	input  logic [7:0]  in_id,
	input  logic [15:0] in_len,
	input  logic [7:0]  in_data,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        q_full
);

	logic        in_frame_q;
	logic [15:0] left_q;
	logic        take;
	logic        is_hdr;

	assign in_ready = !q_full;
	assign take     = in_valid && !q_full;
	assign is_hdr   = (in_kind == REQ_HEADER);

	// classify: headers always go, payload only inside a frame
	always_comb begin
		push_cmd.is_hdr = is_hdr;
		push_cmd.id     = in_id;
		push_cmd.len    = in_len;
		push_cmd.data   = in_data;
		if (is_hdr)
			push_cmd.finish = (in_len == 16'd0);
		else
			push_cmd.finish = (left_q == 16'd1);
		push = take && (is_hdr || in_frame_q);
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= 16'd0;
		end else if (take) begin
			if (is_hdr) begin
				in_frame_q <= (in_len != 16'd0);
				left_q     <= in_len;
			end else if (in_frame_q) begin
				left_q <= left_q - 16'd1;
				if (left_q == 16'd1)
					in_frame_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/cfb_queue.sv =====
module cfb_queue
	import cfb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/cfb_back.sv =====
module cfb_back
	import cfb_pkg::*;
#(
	parameter int PREAMBLE_LEN = PREAMBLE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int STEP_W = $clog2(PREAMBLE_LEN + 3);

	ser_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	cmd_t              cur_q;
	logic              load_cur;
	logic [15:0]       crc_q;
	logic [15:0]       crc_base;
	logic              feed;
	logic              crc_clear;
	logic              emit;
	logic [7:0]        emit_byte;
	logic              emit_last;
	logic              adv;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [7:0]        hdr_byte;

	assign adv       = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	// header byte for the current step
	always_comb begin
		if (step_q < STEP_W'(PREAMBLE_LEN))
			hdr_byte = PREAMBLE_BYTE;
		else if (step_q == STEP_W'(PREAMBLE_LEN))
			hdr_byte = cur_q.id;
		else if (step_q == STEP_W'(PREAMBLE_LEN + 1))
			hdr_byte = cur_q.len[7:0];
		else
			hdr_byte = cur_q.len[15:8];
	end

	// sequencer: next state and the byte to load into the output register
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		pop       = 1'b0;
		load_cur  = 1'b0;
		emit      = 1'b0;
		emit_byte = 8'h00;
		emit_last = 1'b0;
		feed      = 1'b0;
		crc_clear = 1'b0;
		crc_base  = crc_q;
		case (state_q)
			ST_IDLE: begin
				if (adv && !q_empty) begin
					pop  = 1'b1;
					emit = 1'b1;
					feed = 1'b1;
					if (head.is_hdr) begin
						// first preamble byte, checksum restarts
						load_cur  = 1'b1;
						emit_byte = PREAMBLE_BYTE;
						crc_base  = CRC_INIT;
						step_d    = STEP_W'(1);
						state_d   = ST_HDR;
					end else begin
						emit_byte = head.data;
						state_d   = head.finish ? ST_CRC_LO : ST_IDLE;
					end
				end
			end
			ST_HDR: begin
				if (adv) begin
					emit      = 1'b1;
					feed      = 1'b1;
					emit_byte = hdr_byte;
					if (step_q == STEP_W'(PREAMBLE_LEN + 2))
						state_d = cur_q.finish ? ST_CRC_LO : ST_IDLE;
					else
						step_d = step_q + 1'b1;
				end
			end
			ST_CRC_LO: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = crc_q[7:0];
					state_d   = ST_CRC_HI;
				end
			end
			ST_CRC_HI: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = crc_q[15:8];
					emit_last = 1'b1;
					crc_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			crc_q   <= CRC_INIT;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (crc_clear)
				crc_q <= CRC_INIT;
			else if (feed)
				crc_q <= crc_next(crc_base, emit_byte);
		end
	end

	// header being serialized
	always_ff @(posedge clk) begin
		if (load_cur)
			cur_q <= head;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

endmodule

// ===== sv/command_frame_builder_crc16_core.sv =====
// Path: with the serializer idle, an accepted item is written into the queue, then popped by
// the serializer, which loads its first byte into its single output register.
// Throughput: one payload byte per cycle unless m_tready stalls the output; a header is sent as
// PREAMBLE_LEN preamble bytes, id, length low, length high; both checksum bytes follow a zero-length
// header and the last payload byte. The input queue takes requests meanwhile, until it is full.
// Reset: arst_n clears all control state at once; checksum returns to 0xFFFF, block is idle.
module command_frame_builder_crc16_core
	import cfb_pkg::*;
#(
	parameter int PREAMBLE_LEN = PREAMBLE_LEN_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // msg_id[7:0], msg_length[23:8], data_byte[31:24]
	input  logic        s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_empty;
	logic pop;
	cmd_t head;

	cfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_id    (s_tdata[7:0]),
		.in_len   (s_tdata[23:8]),
		.in_data  (s_tdata[31:24]),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	cfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	cfb_back #(
		.PREAMBLE_LEN (PREAMBLE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
